>>> rtl/point_polygon_ring_distance_defines.svh
// Assertion macros shared by the point-to-polygon ring distance RTL.
`ifndef POINT_POLYGON_RING_DISTANCE_DEFINES_SVH
`define POINT_POLYGON_RING_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPR_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ppr_pkg.sv
// Shared types and constants for the point-to-polygon ring distance block.
`timescale 1ns / 1ps
package ppr_pkg;

   localparam int CW    = 21;        // coordinate width
   localparam int DW    = CW + 1;    // coordinate difference
   localparam int MW    = 24;        // multiplier operand
   localparam int PW    = 2 * MW;    // multiplier product
   localparam int LW    = 43;        // squared edge length / squared vertex distance
   localparam int XW    = 44;        // cross and dot products
   localparam int AW    = 43;        // |cross|
   localparam int WW    = 94;        // wide accumulator
   localparam int FRAC  = 16;
   localparam int QW    = 60;        // quotient / near tracker
   localparam int FARW  = 43;
   localparam int NOUTW = 59;
   localparam int AREAW = 61;
   localparam int DIFFW = FARW + FRAC;
   localparam int CH    = 23;        // chunk width for split products
   localparam int STW   = 6;
   localparam int SHW   = 7;

   localparam logic [33:0]   PI_Q32     = 34'd13493037705;
   localparam logic [QW-1:0] NEAR_RESET = {QW{1'b1}};

   localparam logic REG_CENTER_X = 1'b0;
   localparam logic REG_CENTER_Y = 1'b1;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] fx;
      logic signed [CW-1:0] fy;
      logic                 has_prev;
      logic                 last;
   } entry_type;

   typedef enum logic [3:0] {
      B_IDLE, B_VMUL, B_VWAIT, B_VUPD, B_EMUL, B_EWAIT, B_ECLS, B_SMUL,
      B_SWAIT, B_DINIT, B_DIV, B_FIN, B_AMUL, B_AWAIT, B_OUT
   } back_state_type;

   typedef enum logic [3:0] {
      ACC_NONE, ACC_VSQ_SET, ACC_VSQ_ADD, ACC_LSQ_SET, ACC_LSQ_ADD, ACC_CR_SET,
      ACC_CR_SUB, ACC_DOT_SET, ACC_DOT_ADD, ACC_WIDE_SET, ACC_WIDE_ADD
   } acc_dest_type;

   typedef struct packed {
      acc_dest_type   dest;
      logic [SHW-1:0] shift;
   } acc_cmd_type;

endpackage

>>> rtl/ppr_front.sv
// Front end: takes vertex words and tags each with its previous and first vertex.
`timescale 1ns / 1ps
module ppr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [ppr_pkg::CW-1:0] in_x,
   input  logic signed [ppr_pkg::CW-1:0] in_y,
   input  logic                          in_last,
   output logic                          push,
   input  logic                          q_ready,
   output ppr_pkg::entry_type            entry
);

   logic signed [ppr_pkg::CW-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [ppr_pkg::CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                          have_prev_ff, have_prev_in;

   assign in_ready = q_ready;
   assign push     = in_valid && q_ready;

   always_comb begin
      entry.x        = in_x;
      entry.y        = in_y;
      entry.px       = prev_x_ff;
      entry.py       = prev_y_ff;
      entry.fx       = have_prev_ff ? first_x_ff : in_x;
      entry.fy       = have_prev_ff ? first_y_ff : in_y;
      entry.has_prev = have_prev_ff;
      entry.last     = in_last;
      first_x_in     = first_x_ff;
      first_y_in     = first_y_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      have_prev_in   = have_prev_ff;
      if (push) begin
         prev_x_in    = in_x;
         prev_y_in    = in_y;
         have_prev_in = !in_last;
         if (!have_prev_ff) begin
            first_x_in = in_x;
            first_y_in = in_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

>>> rtl/ppr_queue.sv
// Two-entry queue between front end and arithmetic back end.
`timescale 1ns / 1ps
`include "point_polygon_ring_distance_defines.svh"
module ppr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ppr_pkg::entry_type push_data,
   output logic               ready,
   input  logic               pop,
   output logic               valid,
   output ppr_pkg::entry_type pop_data
);

   ppr_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign ready    = count_ff != 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PPR_ASSERT(a_no_overflow, push, count_ff != 2'd2 || pop, "queue overflow")
   `PPR_ASSERT(a_no_underflow, pop, count_ff != 2'd0, "queue underflow")
   `PPR_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 2'd1, "count slip")

endmodule

>>> rtl/ppr_back.sv
// Back end: distance tracking, edge test, serial divider and ring area.
`timescale 1ns / 1ps
`include "point_polygon_ring_distance_defines.svh"
module ppr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [ppr_pkg::CW-1:0]      center_x,
   input  logic signed [ppr_pkg::CW-1:0]      center_y,
   input  logic                               q_valid,
   input  ppr_pkg::entry_type                 q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ppr_pkg::FARW-1:0]           rsp_far,
   output logic [ppr_pkg::NOUTW-1:0]          rsp_near,
   output logic [ppr_pkg::AREAW-1:0]          rsp_area,
   output logic                               rsp_area_valid
);

   localparam int CW = ppr_pkg::CW;
   localparam int DW = ppr_pkg::DW;
   localparam int MW = ppr_pkg::MW;
   localparam int PW = ppr_pkg::PW;
   localparam int LW = ppr_pkg::LW;
   localparam int XW = ppr_pkg::XW;
   localparam int AW = ppr_pkg::AW;
   localparam int WW = ppr_pkg::WW;
   localparam int QW = ppr_pkg::QW;
   localparam int FRAC = ppr_pkg::FRAC;
   localparam int CH = ppr_pkg::CH;
   localparam int STW = ppr_pkg::STW;
   localparam int SHW = ppr_pkg::SHW;
   localparam int FARW = ppr_pkg::FARW;
   localparam int DIFFW = ppr_pkg::DIFFW;

   ppr_pkg::back_state_type state_ff, state_in;
   logic [STW-1:0]          step_ff, step_in;
   ppr_pkg::entry_type      ent_ff, ent_in;
   logic                    cls_ff, cls_in;
   logic signed [DW-1:0]    ux_ff, ux_in, uy_ff, uy_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [MW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    mul_ff, mul_in;
   ppr_pkg::acc_cmd_type    cmd_ff, cmd_in;
   logic [LW-1:0]           vsq_ff, vsq_in, lsq_ff, lsq_in;
   logic signed [XW-1:0]    cr_ff, cr_in, dot_ff, dot_in;
   logic [WW-1:0]           wide_ff, wide_in, wide_prod, rnd;
   logic [AW-1:0]           acr_ff, acr_in;
   logic [LW-1:0]           rem_ff, rem_in;
   logic [LW:0]             trial;
   logic                    ge;
   logic [QW-1:0]           qn_ff, qn_in, near_ff, near_in, near_cand;
   logic [FARW-1:0]         far_ff, far_in;
   logic [DIFFW-1:0]        diff_ff, diff_in, fq;
   logic                    seen_l_ff, seen_l_in, seen_r_ff, seen_r_in;
   logic                    on_edge_ff, on_edge_in, av_ff, av_in;
   logic                    rsp_valid_ff, rsp_valid_in, rsp_av_ff, rsp_av_in;
   logic [FARW-1:0]         rsp_far_ff, rsp_far_in;
   logic [ppr_pkg::NOUTW-1:0] rsp_near_ff, rsp_near_in;
   logic [ppr_pkg::AREAW-1:0] rsp_area_ff, rsp_area_in;
   logic signed [DW-1:0]    dx, dy, pux, puy, pvx, pvy, cux, cuy, cvx, cvy;
   logic                    proj_on, setup_prev, setup_close, edge_end;

   // operand differences straight from the held entry
   assign dx  = DW'(ent_ff.x) - DW'(center_x);
   assign dy  = DW'(ent_ff.y) - DW'(center_y);
   assign pux = DW'(ent_ff.x) - DW'(ent_ff.px);
   assign puy = DW'(ent_ff.y) - DW'(ent_ff.py);
   assign pvx = DW'(center_x) - DW'(ent_ff.px);
   assign pvy = DW'(center_y) - DW'(ent_ff.py);
   assign cux = DW'(ent_ff.fx) - DW'(ent_ff.x);
   assign cuy = DW'(ent_ff.fy) - DW'(ent_ff.y);
   assign cvx = DW'(center_x) - DW'(ent_ff.x);
   assign cvy = DW'(center_y) - DW'(ent_ff.y);

   assign proj_on = !dot_ff[XW-1] && ($unsigned(dot_ff) <= XW'(lsq_ff));
   assign trial  = {rem_ff, qn_ff[QW-1]};
   assign ge     = trial >= {1'b0, lsq_ff};
   assign fq     = {far_ff, {FRAC{1'b0}}};
   assign rnd    = wide_ff + (WW'(1) << 31);
   assign mul_in = mul_a * mul_b;

   // accumulate the registered product into the destination named by its registered command
   always_comb begin
      vsq_in    = vsq_ff;
      lsq_in    = lsq_ff;
      cr_in     = cr_ff;
      dot_in    = dot_ff;
      wide_in   = wide_ff;
      wide_prod = WW'(mul_ff[PW-1:0]) << cmd_ff.shift;
      case (cmd_ff.dest)
         ppr_pkg::ACC_VSQ_SET:  vsq_in  = mul_ff[LW-1:0];
         ppr_pkg::ACC_VSQ_ADD:  vsq_in  = vsq_ff + mul_ff[LW-1:0];
         ppr_pkg::ACC_LSQ_SET:  lsq_in  = mul_ff[LW-1:0];
         ppr_pkg::ACC_LSQ_ADD:  lsq_in  = lsq_ff + mul_ff[LW-1:0];
         ppr_pkg::ACC_CR_SET:   cr_in   = mul_ff[XW-1:0];
         ppr_pkg::ACC_CR_SUB:   cr_in   = cr_ff - mul_ff[XW-1:0];
         ppr_pkg::ACC_DOT_SET:  dot_in  = mul_ff[XW-1:0];
         ppr_pkg::ACC_DOT_ADD:  dot_in  = dot_ff + mul_ff[XW-1:0];
         ppr_pkg::ACC_WIDE_SET: wide_in = wide_prod;
         ppr_pkg::ACC_WIDE_ADD: wide_in = wide_ff + wide_prod;
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ent_in       = ent_ff;
      cls_in       = cls_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      mul_a        = '0;
      mul_b        = '0;
      cmd_in       = '{dest: ppr_pkg::ACC_NONE, shift: '0};
      acr_in       = acr_ff;
      rem_in       = rem_ff;
      qn_in        = qn_ff;
      far_in       = far_ff;
      near_in      = near_ff;
      near_cand    = QW'({vsq_ff, {FRAC{1'b0}}});
      diff_in      = diff_ff;
      seen_l_in    = seen_l_ff;
      seen_r_in    = seen_r_ff;
      on_edge_in   = on_edge_ff;
      av_in        = av_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_av_in    = rsp_av_ff;
      rsp_far_in   = rsp_far_ff;
      rsp_near_in  = rsp_near_ff;
      rsp_area_in  = rsp_area_ff;
      q_pop        = 1'b0;
      setup_prev   = 1'b0;
      setup_close  = 1'b0;
      edge_end     = 1'b0;
      case (state_ff)
         ppr_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ent_in   = q_data;
               step_in  = '0;
               state_in = ppr_pkg::B_VMUL;
            end
         end
         ppr_pkg::B_VMUL: begin
            if (step_ff == '0) begin
               mul_a = MW'(dx);
               mul_b = MW'(dx);
               cmd_in.dest = ppr_pkg::ACC_VSQ_SET;
               step_in = step_ff + 1'b1;
            end else begin
               mul_a = MW'(dy);
               mul_b = MW'(dy);
               cmd_in.dest = ppr_pkg::ACC_VSQ_ADD;
               state_in = ppr_pkg::B_VWAIT;
            end
         end
         ppr_pkg::B_VWAIT: state_in = ppr_pkg::B_VUPD;
         ppr_pkg::B_VUPD: begin
            if (vsq_ff > far_ff) far_in = vsq_ff;
            if (near_cand < near_ff) near_in = near_cand;
            if (ent_ff.has_prev) begin
               setup_prev = 1'b1;
            end else if (ent_ff.last) begin
               setup_close = 1'b1;
            end else begin
               state_in = ppr_pkg::B_IDLE;
            end
         end
         ppr_pkg::B_EMUL: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               STW'(0): begin
                  mul_a = MW'(ux_ff); mul_b = MW'(ux_ff);
                  cmd_in.dest = ppr_pkg::ACC_LSQ_SET;
               end
               STW'(1): begin
                  mul_a = MW'(uy_ff); mul_b = MW'(uy_ff);
                  cmd_in.dest = ppr_pkg::ACC_LSQ_ADD;
               end
               STW'(2): begin
                  mul_a = MW'(ux_ff); mul_b = MW'(vy_ff);
                  cmd_in.dest = ppr_pkg::ACC_CR_SET;
               end
               STW'(3): begin
                  mul_a = MW'(uy_ff); mul_b = MW'(vx_ff);
                  cmd_in.dest = ppr_pkg::ACC_CR_SUB;
               end
               STW'(4): begin
                  mul_a = MW'(ux_ff); mul_b = MW'(vx_ff);
                  cmd_in.dest = ppr_pkg::ACC_DOT_SET;
               end
               default: begin
                  mul_a = MW'(uy_ff); mul_b = MW'(vy_ff);
                  cmd_in.dest = ppr_pkg::ACC_DOT_ADD;
                  state_in = ppr_pkg::B_EWAIT;
               end
            endcase
         end
         ppr_pkg::B_EWAIT: state_in = ppr_pkg::B_ECLS;
         ppr_pkg::B_ECLS: begin
            if (lsq_ff == '0) begin
               edge_end = 1'b1;
            end else if (cr_ff == '0) begin
               if (proj_on) on_edge_in = 1'b1;
               edge_end = 1'b1;
            end else begin
               if (cr_ff[XW-1]) seen_l_in = 1'b1;
               else seen_r_in = 1'b1;
               if (proj_on) begin
                  acr_in   = cr_ff[XW-1] ? AW'(-cr_ff) : AW'(cr_ff);
                  step_in  = '0;
                  state_in = ppr_pkg::B_SMUL;
               end else begin
                  edge_end = 1'b1;
               end
            end
         end
         ppr_pkg::B_SMUL: begin
            // |cr|^2 from two chunks, the cross term doubled by its shift
            step_in = step_ff + 1'b1;
            case (step_ff)
               STW'(0): begin
                  mul_a = MW'(acr_ff[CH-1:0]); mul_b = MW'(acr_ff[CH-1:0]);
                  cmd_in = '{dest: ppr_pkg::ACC_WIDE_SET, shift: SHW'(0)};
               end
               STW'(1): begin
                  mul_a = MW'(acr_ff[CH-1:0]); mul_b = MW'(acr_ff[AW-1:CH]);
                  cmd_in = '{dest: ppr_pkg::ACC_WIDE_ADD, shift: SHW'(CH + 1)};
               end
               default: begin
                  mul_a = MW'(acr_ff[AW-1:CH]); mul_b = MW'(acr_ff[AW-1:CH]);
                  cmd_in = '{dest: ppr_pkg::ACC_WIDE_ADD, shift: SHW'(2 * CH)};
                  state_in = ppr_pkg::B_SWAIT;
               end
            endcase
         end
         ppr_pkg::B_SWAIT: state_in = ppr_pkg::B_DINIT;
         ppr_pkg::B_DINIT: begin
            rem_in   = wide_ff[QW-FRAC+LW-1:QW-FRAC];
            qn_in    = {wide_ff[QW-FRAC-1:0], {FRAC{1'b0}}};
            step_in  = '0;
            state_in = ppr_pkg::B_DIV;
         end
         ppr_pkg::B_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in  = ge ? LW'(trial - {1'b0, lsq_ff}) : trial[LW-1:0];
            qn_in   = {qn_ff[QW-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STW'(QW - 1)) begin
               if (qn_in < near_ff) near_in = qn_in;
               edge_end = 1'b1;
            end
         end
         ppr_pkg::B_FIN: begin
            av_in = seen_l_ff && seen_r_ff && !on_edge_ff;
            if (av_in) begin
               diff_in  = (QW'(fq) > near_ff) ? DIFFW'(QW'(fq) - near_ff) : '0;
               step_in  = '0;
               state_in = ppr_pkg::B_AMUL;
            end else begin
               state_in = ppr_pkg::B_OUT;
            end
         end
         ppr_pkg::B_AMUL: begin
            // diff * pi in Q32: three diff chunks by two pi chunks
            step_in = step_ff + 1'b1;
            cmd_in.dest = ppr_pkg::ACC_WIDE_ADD;
            case (step_ff)
               STW'(0): begin
                  mul_a = MW'(diff_ff[CH-1:0]); mul_b = MW'(ppr_pkg::PI_Q32[CH-1:0]);
                  cmd_in = '{dest: ppr_pkg::ACC_WIDE_SET, shift: SHW'(0)};
               end
               STW'(1): begin
                  mul_a = MW'(diff_ff[CH-1:0]); mul_b = MW'(ppr_pkg::PI_Q32[33:CH]);
                  cmd_in.shift = SHW'(CH);
               end
               STW'(2): begin
                  mul_a = MW'(diff_ff[2*CH-1:CH]); mul_b = MW'(ppr_pkg::PI_Q32[CH-1:0]);
                  cmd_in.shift = SHW'(CH);
               end
               STW'(3): begin
                  mul_a = MW'(diff_ff[2*CH-1:CH]); mul_b = MW'(ppr_pkg::PI_Q32[33:CH]);
                  cmd_in.shift = SHW'(2 * CH);
               end
               STW'(4): begin
                  mul_a = MW'(diff_ff[DIFFW-1:2*CH]); mul_b = MW'(ppr_pkg::PI_Q32[CH-1:0]);
                  cmd_in.shift = SHW'(2 * CH);
               end
               default: begin
                  mul_a = MW'(diff_ff[DIFFW-1:2*CH]); mul_b = MW'(ppr_pkg::PI_Q32[33:CH]);
                  cmd_in.shift = SHW'(3 * CH);
                  state_in = ppr_pkg::B_AWAIT;
               end
            endcase
         end
         ppr_pkg::B_AWAIT: state_in = ppr_pkg::B_OUT;
         ppr_pkg::B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_far_in   = far_ff;
               rsp_near_in  = near_ff[ppr_pkg::NOUTW-1:0];
               rsp_area_in  = av_ff ? rnd[32+ppr_pkg::AREAW-1:32] : '0;
               rsp_av_in    = av_ff;
               far_in       = '0;
               near_in      = ppr_pkg::NEAR_RESET;
               seen_l_in    = 1'b0;
               seen_r_in    = 1'b0;
               on_edge_in   = 1'b0;
               state_in     = ppr_pkg::B_IDLE;
            end
         end
         default: state_in = ppr_pkg::B_IDLE;
      endcase

      if (edge_end) begin
         if (!cls_ff && ent_ff.last) setup_close = 1'b1;
         else if (ent_ff.last) state_in = ppr_pkg::B_FIN;
         else state_in = ppr_pkg::B_IDLE;
      end
      if (setup_prev) begin
         cls_in = 1'b0;
         ux_in = pux; uy_in = puy; vx_in = pvx; vy_in = pvy;
      end
      if (setup_close) begin
         cls_in = 1'b1;
         ux_in = cux; uy_in = cuy; vx_in = cvx; vy_in = cvy;
      end
      if (setup_prev || setup_close) begin
         step_in  = '0;
         state_in = ppr_pkg::B_EMUL;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      cls_ff      <= cls_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      mul_ff      <= mul_in;
      vsq_ff      <= vsq_in;
      lsq_ff      <= lsq_in;
      cr_ff       <= cr_in;
      dot_ff      <= dot_in;
      wide_ff     <= wide_in;
      acr_ff      <= acr_in;
      rem_ff      <= rem_in;
      qn_ff       <= qn_in;
      diff_ff     <= diff_in;
      av_ff       <= av_in;
      rsp_far_ff  <= rsp_far_in;
      rsp_near_ff <= rsp_near_in;
      rsp_area_ff <= rsp_area_in;
      rsp_av_ff   <= rsp_av_in;
      if (reset) begin
         state_ff     <= ppr_pkg::B_IDLE;
         step_ff      <= '0;
         cmd_ff       <= '{dest: ppr_pkg::ACC_NONE, shift: '0};
         far_ff       <= '0;
         near_ff      <= ppr_pkg::NEAR_RESET;
         seen_l_ff    <= 1'b0;
         seen_r_ff    <= 1'b0;
         on_edge_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cmd_ff       <= cmd_in;
         far_ff       <= far_in;
         near_ff      <= near_in;
         seen_l_ff    <= seen_l_in;
         seen_r_ff    <= seen_r_in;
         on_edge_ff   <= on_edge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_far        = rsp_far_ff;
   assign rsp_near       = rsp_near_ff;
   assign rsp_area       = rsp_area_ff;
   assign rsp_area_valid = rsp_av_ff;

   `PPR_ASSERT(a_div_rem, state_ff == ppr_pkg::B_DIV, rem_ff < lsq_ff, "remainder not below divisor")
   `PPR_ASSERT(a_idle_drained, state_ff == ppr_pkg::B_IDLE, cmd_ff.dest == ppr_pkg::ACC_NONE, "product pending in idle")
   `PPR_ASSERT(a_near_le_far, far_ff != '0, near_ff <= QW'(fq), "near above far")

endmodule

>>> rtl/point_polygon_ring_distance.sv
// Per vertex the back end pops the word, forms two squares, accumulates and updates; each edge
// test adds its products and classification, plus 3 square partials and a 60-step divider when
// the projection lands on the edge. Last vertex also runs the closing edge, then area product,
// rounding and load. A vertex is popped only once the last is done; the divider is one bit a cycle.
// A two-word queue lets vertex words be taken while the back end is busy.
// Reset: synchronous, active high; clears centre, polygon tracking, queue and rsp_tvalid.
`timescale 1ns / 1ps
module point_polygon_ring_distance (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // vertex_x[20:0], vertex_y[41:21], zero pad
   input  logic         req_tlast,   // last_vertex
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,   // far_sq[42:0], near_sq_q16[101:43],
                                     // ring_area_q16[162:102], zero pad
   output logic [0:0]   rsp_tuser,   // area_valid
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [20:0]  csr_data
);

   // centre point registers
   logic signed [ppr_pkg::CW-1:0] center_x_ff, center_x_in, center_y_ff, center_y_in;

   logic                          push, q_ready, q_valid, q_pop;
   ppr_pkg::entry_type            push_data, pop_data;
   logic [ppr_pkg::FARW-1:0]      far_sq;
   logic [ppr_pkg::NOUTW-1:0]     near_sq;
   logic [ppr_pkg::AREAW-1:0]     area;
   logic                          area_valid;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_we) begin
         case (csr_index)
            ppr_pkg::REG_CENTER_X: center_x_in = csr_data;
            ppr_pkg::REG_CENTER_Y: center_y_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   // front: tag each word with the previous and first vertex of its polygon
   ppr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_x     (req_tdata[20:0]),
      .in_y     (req_tdata[41:21]),
      .in_last  (req_tlast),
      .push     (push),
      .q_ready  (q_ready),
      .entry    (push_data)
   );

   ppr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   // back: shared multiplier, edge test, divider, area; holds the output register
   ppr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .center_x       (center_x_ff),
      .center_y       (center_y_ff),
      .q_valid        (q_valid),
      .q_data         (pop_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_far        (far_sq),
      .rsp_near       (near_sq),
      .rsp_area       (area),
      .rsp_area_valid (area_valid)
   );

   assign rsp_tdata = {5'b0, area, near_sq, far_sq};
   assign rsp_tuser = area_valid;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the point-to-polygon ring distance block.
`timescale 1ns / 1ps

// Tracks one polygon per run of vertex words and queues the expected ring result.
class ring_scoreboard;
   typedef struct packed {
      logic [42:0] far_sq;
      logic [58:0] near_sq;
      logic [60:0] area;
      logic        valid;
   } ring_result_type;

   ring_result_type pending_rings[$];
   int unsigned  fail_count;

   longint ctr_x, ctr_y;
   longint first_x, first_y, prev_x, prev_y;
   bit     have_prev, seen_left, seen_right, on_edge;
   logic [42:0] far_track;
   logic [59:0] near_track;

   function new();
      ctr_x = 0;
      ctr_y = 0;
      fail_count = 0;
      clear_polygon();
   endfunction

   function void clear_polygon();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      have_prev = 0; seen_left = 0; seen_right = 0; on_edge = 0;
      far_track = '0;
      near_track = {60{1'b1}};
   endfunction

   function void set_centre(bit idx, logic signed [20:0] v);
      if (idx == ppr_pkg::REG_CENTER_X) ctr_x = v;
      else ctr_y = v;
   endfunction

   function void vertex_dist(longint x, longint y);
      longint dx, dy;
      logic [63:0] sq;
      logic [63:0] q;
      dx = x - ctr_x;
      dy = y - ctr_y;
      sq = dx * dx + dy * dy;
      q  = sq << 16;
      if (sq > far_track) far_track = sq[42:0];
      if (q < near_track) near_track = q[59:0];
   endfunction

   function void edge_test(longint x1, longint y1, longint x2, longint y2);
      longint ux, uy, vx, vy, lsq, cr, dot;
      logic [127:0] num;
      logic [127:0] q;
      logic [63:0]  acr;
      bit proj_on;
      ux = x2 - x1; uy = y2 - y1;
      vx = ctr_x - x1; vy = ctr_y - y1;
      lsq = ux * ux + uy * uy;
      if (lsq == 0) return;
      cr  = ux * vy - uy * vx;
      dot = ux * vx + uy * vy;
      proj_on = dot >= 0 && dot <= lsq;
      if (cr == 0) begin
         if (proj_on) on_edge = 1;
         return;
      end
      if (cr > 0) seen_right = 1;
      else seen_left = 1;
      if (!proj_on) return;
      acr = cr < 0 ? -cr : cr;
      num = ({64'd0, acr} * {64'd0, acr}) << 16;
      q = num / lsq;
      if (q < near_track) near_track = q[59:0];
   endfunction

   // Accepted vertex word: update polygon state, queue a result on the last one.
   function void note_vertex(logic signed [20:0] vx, logic signed [20:0] vy, bit last);
      longint x, y;
      ring_result_type r;
      logic [63:0]  diff;
      logic [127:0] prod;
      logic [63:0]  fq;
      x = vx;
      y = vy;
      vertex_dist(x, y);
      if (have_prev) edge_test(prev_x, prev_y, x, y);
      else begin
         first_x = x;
         first_y = y;
      end
      prev_x = x; prev_y = y; have_prev = 1;
      if (!last) return;
      edge_test(x, y, first_x, first_y);
      r.valid = seen_left && seen_right && !on_edge;
      r.area = '0;
      if (r.valid) begin
         fq = {21'd0, far_track} << 16;
         diff = fq > near_track ? fq - near_track : 64'd0;
         prod = {64'd0, diff} * 128'd13493037705 + (128'd1 << 31);
         r.area = prod[92:32];
      end
      r.far_sq = far_track;
      r.near_sq = near_track[58:0];
      pending_rings.push_back(r);
      clear_polygon();
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0d, want %0d", what, got, want);
      fail_count++;
   endtask

   task check_ring(logic [167:0] data, logic valid);
      ring_result_type e;
      if (pending_rings.size() == 0) begin
         report("unexpected result word", 64'd1, 64'd0);
         return;
      end
      e = pending_rings.pop_front();
      if (data[42:0] !== e.far_sq) report("far_sq", 64'(data[42:0]), 64'(e.far_sq));
      if (data[101:43] !== e.near_sq)
         report("near_sq_q16", 64'(data[101:43]), 64'(e.near_sq));
      if (data[162:102] !== e.area)
         report("ring_area_q16", 64'(data[162:102]), 64'(e.area));
      if (valid !== e.valid) report("area_valid", 64'(valid), 64'(e.valid));
   endtask
endclass

module tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;   // vertex_x, vertex_y, pad
   logic         req_tlast = 0;    // last_vertex
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [167:0] rsp_tdata;        // far_sq, near_sq_q16, ring_area_q16, pad
   logic [0:0]   rsp_tuser;        // area_valid
   logic         csr_we = 0;
   logic [0:0]   csr_index = '0;
   logic [20:0]  csr_data = '0;

   ring_scoreboard rings = new();

   int  send_idle_pct = 0;   // sender gap chance, per cent
   int  recv_stall_pct = 0;  // receiver stall chance, per cent
   bit  hold_off = 0;        // long receiver hold-off in progress
   int  idle_cycles = 0;

   point_polygon_ring_distance dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Receiver: random stalls, or a hard hold-off while the input fills up.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && !reset) rings.check_ring(rsp_tdata, rsp_tuser[0]);
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_centre(bit idx, logic signed [20:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      rings.set_centre(idx, v);
   endtask

   // One vertex word; valid stays high across back-to-back words.
   task automatic send_vertex(logic signed [20:0] x, logic signed [20:0] y, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, y, x};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      rings.note_vertex(x, y, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (rings.pending_rings.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [20:0] rand_coord();
      case ($urandom_range(9))
         0: return 21'sh0FFFFF;
         1: return 21'sh100000;
         2: return 21'($urandom);        // raw bit pattern, any value
         3, 4: return 21'($urandom_range(40) - 20);
         default: return 21'($urandom_range(2000000) - 1000000);
      endcase
   endfunction

   task automatic random_polygon(int max_len);
      int n = $urandom_range(max_len, 1);
      for (int i = 0; i < n; i++) send_vertex(rand_coord(), rand_coord(), i == n - 1);
   endtask

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      write_centre(ppr_pkg::REG_CENTER_X, 21'sd0);
      write_centre(ppr_pkg::REG_CENTER_Y, 21'sd0);

      // Directed: square round the centre, single vertex, on-edge, collinear outside,
      // zero-length edge, extreme coordinates.
      send_vertex(-21'sd10, -21'sd10, 1'b0); send_vertex(21'sd10, -21'sd10, 1'b0);
      send_vertex(21'sd10, 21'sd10, 1'b0);   send_vertex(-21'sd10, 21'sd10, 1'b1);
      send_vertex(21'sd5, 21'sd7, 1'b1);
      send_vertex(-21'sd5, 21'sd0, 1'b0); send_vertex(21'sd5, 21'sd0, 1'b0);
      send_vertex(21'sd0, 21'sd9, 1'b1);
      send_vertex(21'sd3, 21'sd0, 1'b0); send_vertex(21'sd8, 21'sd0, 1'b1);
      send_vertex(21'sd4, 21'sd4, 1'b0); send_vertex(21'sd4, 21'sd4, 1'b0);
      send_vertex(-21'sd4, 21'sd4, 1'b0);
      send_vertex(21'sd0, -21'sd6, 1'b1);
      send_vertex(21'sh0FFFFF, 21'sh0FFFFF, 1'b0); send_vertex(21'sh100000, 21'sh0FFFFF, 1'b0);
      send_vertex(21'sh100000, 21'sh100000, 1'b0); send_vertex(21'sh0FFFFF, 21'sh100000, 1'b1);
      drain();

      write_centre(ppr_pkg::REG_CENTER_X, 21'sh0FFFFF);
      write_centre(ppr_pkg::REG_CENTER_Y, 21'sh100000);
      send_vertex(21'sh100000, 21'sh0FFFFF, 1'b0); send_vertex(21'sd0, 21'sd0, 1'b0);
      send_vertex(21'sh0FFFFF, 21'sh0FFFFF, 1'b1);
      drain();

      // Random phases across idling settings and centres.
      sent = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         write_centre(ppr_pkg::REG_CENTER_X, phase == 4 ? 21'sh100000 : rand_coord());
         write_centre(ppr_pkg::REG_CENTER_Y, phase == 4 ? 21'sh0FFFFF : rand_coord());
         if (phase == 2) begin
            // Long receiver hold-off while vertices keep coming.
            fork
               begin
                  hold_off = 1;
                  repeat (3000) @(posedge clock);
                  hold_off = 0;
               end
               begin
                  repeat (10) random_polygon(3);
                  req_tvalid <= 1'b0;
               end
            join
         end
         for (int k = 0; k < 70; k++) begin
            random_polygon(k % 10 == 0 ? 12 : 4);
            if (k == 35) begin
               // Sender waits for every outstanding result.
               req_tvalid <= 1'b0;
               while (rings.pending_rings.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (rings.fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl
rtl/ppr_pkg.sv
rtl/ppr_front.sv
rtl/ppr_queue.sv
rtl/ppr_back.sv
rtl/point_polygon_ring_distance.sv
tb/sv/tb.sv
